@@ design/kmst_pkg.sv @@
// kmst_pkg: shared types and constants for the Kruskal spanning tree unit.
// No dependencies.
package kmst_pkg;
  localparam int MaxVertices = 64;
  localparam int VidW        = 6;
  localparam int MaxEdges    = 256;
  localparam int CntW        = 9;
  localparam int WeightW     = 16;
  localparam int SumW        = 22;
  localparam int KeyW        = WeightW + 2 * VidW;
  localparam int VcW         = 7;

  // sort key: weight with inverted sign bit, then source, then destination
  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } sort_ctrl_t;

  typedef struct packed {
    logic            en;
    logic            clear;
    logic [VidW-1:0] from;
    logic [VidW-1:0] to;
  } merge_t;
endpackage

@@ design/kmst_sort_cell.sv @@
// kmst_sort_cell: one slot of the systolic insertion sorter.
// Depends on kmst_pkg.
module kmst_sort_cell import kmst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sort_ctrl_t ctrl_i,
  input  key_t       new_key_i,
  input  key_t       left_key_i,
  input  logic       left_valid_i,
  input  logic       left_gt_i,
  input  key_t       right_key_i,
  input  logic       right_valid_i,
  output key_t       key_o,
  output logic       valid_o,
  output logic       gt_o
);
  key_t key_q, key_d;
  logic valid_q, valid_d;

  assign gt_o    = !valid_q || (new_key_i < key_q);
  assign key_o   = key_q;
  assign valid_o = valid_q;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end else begin
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end
endmodule

@@ design/kmst_vertex_cell.sv @@
// kmst_vertex_cell: component label of one vertex for set membership.
// Depends on kmst_pkg.
module kmst_vertex_cell import kmst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [VidW-1:0] idx_i,
  input  logic [VidW-1:0] src_i,
  input  logic [VidW-1:0] dst_i,
  input  merge_t          merge_i,
  output logic [VidW-1:0] src_lab_o,
  output logic [VidW-1:0] dst_lab_o
);
  logic [VidW-1:0] lab_q;
  logic            ok_q;
  logic [VidW-1:0] lab;

  assign lab       = ok_q ? lab_q : idx_i;
  assign src_lab_o = (src_i == idx_i) ? lab : '0;
  assign dst_lab_o = (dst_i == idx_i) ? lab : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (merge_i.clear) begin
      ok_q <= 1'b0;
    end else if (merge_i.en && lab == merge_i.from) begin
      ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!merge_i.clear && merge_i.en && lab == merge_i.from) begin
      lab_q <= merge_i.to;
    end
  end
endmodule

@@ design/kruskal_minimum_spanning_tree_unit.sv @@
// kruskal_minimum_spanning_tree_unit: top level, sorter chain plus vertex cells.
// Depends on kmst_pkg, kmst_sort_cell, kmst_vertex_cell.
//
//  channel  | handshake                | payload
//  edge in  | start_i, busy_o          | src_vertex_i dst_vertex_i weight_i last_edge_i
//  result   | result_valid_o (strobe)  | edge_valid_o tree_* total_weight_o run_end_o dropped_flag_o
//  config   | cfg_we_i                 | cfg_wdata_i (vertex_count)
//
// Edges load at one per cycle into the sorter chain while the unit is not
// busy. After the last edge the unit stays busy while each stored edge passes
// through the label cells in turn, then issues the summary. Results are registered
// and cannot be stalled. Reset clears the chain valid bits and vertex labels at once.
module kruskal_minimum_spanning_tree_unit import kmst_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [VidW-1:0]           src_vertex_i,
  input  logic [VidW-1:0]           dst_vertex_i,
  input  logic signed [WeightW-1:0] weight_i,
  input  logic                      last_edge_i,
  input  logic                      cfg_we_i,
  input  logic [VcW-1:0]            cfg_wdata_i,
  output logic                      result_valid_o,
  output logic                      edge_valid_o,
  output logic [VidW-1:0]           tree_src_o,
  output logic [VidW-1:0]           tree_dst_o,
  output logic signed [WeightW-1:0] tree_weight_o,
  output logic signed [SumW-1:0]    total_weight_o,
  output logic                      run_end_o,
  output logic                      dropped_flag_o
);
  typedef enum logic {ST_LOAD, ST_SCAN} state_e;

  state_e             state_q;
  logic [VcW-1:0]     vc_q;
  logic [CntW-1:0]    cnt_q, rem_q;
  logic [VidW-1:0]    acc_q;
  logic               drop_q;
  logic signed [SumW-1:0] sum_q;

  logic               take, in_ok;
  logic [VcW-1:0]     n_eff;
  key_t               new_key;
  sort_ctrl_t         sctrl;
  merge_t             merge;

  key_t               ck   [MaxEdges];
  logic               cv   [MaxEdges];
  logic               cgt  [MaxEdges];

  logic [VidW-1:0]    sl [MaxVertices];
  logic [VidW-1:0]    dl [MaxVertices];
  logic [VidW-1:0]    ls, ld;

  logic [VidW-1:0]    e_s, e_d;
  logic signed [WeightW-1:0] e_w;
  logic               scan_edge, accept;
  logic signed [SumW:0] t;
  logic signed [SumW-1:0] t_sat;

  assign busy_o  = (state_q != ST_LOAD);
  assign take    = start_i && !busy_o;
  assign n_eff   = (vc_q > VcW'(MaxVertices)) ? VcW'(MaxVertices) : vc_q;
  assign in_ok   = ({1'b0, src_vertex_i} < n_eff) && ({1'b0, dst_vertex_i} < n_eff)
                   && (cnt_q < CntW'(MaxEdges));
  assign new_key = {~weight_i[WeightW-1], weight_i[WeightW-2:0], src_vertex_i, dst_vertex_i};

  assign scan_edge = (state_q == ST_SCAN) && (rem_q != '0);
  assign sctrl.ins   = take && in_ok;
  assign sctrl.shift = scan_edge;

  for (genvar i = 0; i < MaxEdges; i++) begin : g_sort
    if (i == 0) begin : g_first
      kmst_sort_cell u_cell (
        .clk_i, .rst_ni, .ctrl_i(sctrl), .new_key_i(new_key),
        .left_key_i(new_key), .left_valid_i(1'b0), .left_gt_i(1'b0),
        .right_key_i(ck[i+1]), .right_valid_i(cv[i+1]),
        .key_o(ck[i]), .valid_o(cv[i]), .gt_o(cgt[i])
      );
    end else if (i == MaxEdges - 1) begin : g_last
      kmst_sort_cell u_cell (
        .clk_i, .rst_ni, .ctrl_i(sctrl), .new_key_i(new_key),
        .left_key_i(ck[i-1]), .left_valid_i(cv[i-1]), .left_gt_i(cgt[i-1]),
        .right_key_i(new_key), .right_valid_i(1'b0),
        .key_o(ck[i]), .valid_o(cv[i]), .gt_o(cgt[i])
      );
    end else begin : g_mid
      kmst_sort_cell u_cell (
        .clk_i, .rst_ni, .ctrl_i(sctrl), .new_key_i(new_key),
        .left_key_i(ck[i-1]), .left_valid_i(cv[i-1]), .left_gt_i(cgt[i-1]),
        .right_key_i(ck[i+1]), .right_valid_i(cv[i+1]),
        .key_o(ck[i]), .valid_o(cv[i]), .gt_o(cgt[i])
      );
    end
  end

  assign e_w = {~ck[0][KeyW-1], ck[0][KeyW-2:2*VidW]};
  assign e_s = ck[0][2*VidW-1:VidW];
  assign e_d = ck[0][VidW-1:0];

  for (genvar v = 0; v < MaxVertices; v++) begin : g_vert
    kmst_vertex_cell u_vcell (
      .clk_i, .rst_ni, .idx_i(VidW'(v)), .src_i(e_s), .dst_i(e_d),
      .merge_i(merge), .src_lab_o(sl[v]), .dst_lab_o(dl[v])
    );
  end

  always_comb begin
    ls = '0;
    ld = '0;
    for (int v = 0; v < MaxVertices; v++) begin
      ls = ls | sl[v];
      ld = ld | dl[v];
    end
  end

  assign accept      = scan_edge && (ls != ld) && (acc_q != VidW'(MaxVertices - 1));
  assign merge.en    = accept;
  assign merge.from  = ld;
  assign merge.to    = ls;
  assign merge.clear = (state_q == ST_SCAN) && (rem_q == '0);

  assign t     = {sum_q[SumW-1], sum_q} + (SumW+1)'(e_w);
  assign t_sat = (t[SumW] != t[SumW-1]) ? {t[SumW], {(SumW-1){~t[SumW]}}} : t[SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      vc_q           <= VcW'(MaxVertices);
      cnt_q          <= '0;
      rem_q          <= '0;
      acc_q          <= '0;
      drop_q         <= 1'b0;
      sum_q          <= '0;
      result_valid_o <= 1'b0;
      edge_valid_o   <= 1'b0;
      run_end_o      <= 1'b0;
      dropped_flag_o <= 1'b0;
      tree_src_o     <= '0;
      tree_dst_o     <= '0;
      tree_weight_o  <= '0;
      total_weight_o <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_LOAD: begin
          if (take) begin
            if (in_ok) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
            if (last_edge_i) begin
              rem_q   <= in_ok ? cnt_q + 1'b1 : cnt_q;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rem_q != '0) begin
            rem_q <= rem_q - 1'b1;
            if (accept) begin
              acc_q          <= acc_q + 1'b1;
              sum_q          <= t_sat;
              result_valid_o <= 1'b1;
              edge_valid_o   <= 1'b1;
              run_end_o      <= 1'b0;
              dropped_flag_o <= drop_q;
              tree_src_o     <= e_s;
              tree_dst_o     <= e_d;
              tree_weight_o  <= e_w;
              total_weight_o <= t_sat;
            end
          end else begin
            result_valid_o <= 1'b1;
            edge_valid_o   <= 1'b0;
            run_end_o      <= 1'b1;
            dropped_flag_o <= drop_q;
            tree_src_o     <= '0;
            tree_dst_o     <= '0;
            tree_weight_o  <= '0;
            total_weight_o <= sum_q;
            cnt_q          <= '0;
            acc_q          <= '0;
            sum_q          <= '0;
            drop_q         <= 1'b0;
            state_q        <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && run_end_o) |-> !busy_o) else $error("summary while busy");
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(busy_o)) else $error("result outside a run");
  a_edge_nend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && edge_valid_o) |-> !run_end_o) else $error("edge marked end");
`endif
endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for kruskal_minimum_spanning_tree_unit.
// Edges go in through a queue-fed driver; an in-bench union-find model predicts
// the tree edges and summary, and a monitor checks each result strobe.
`timescale 1ns / 100ps

module testbench;
  import kmst_pkg::*;

  typedef struct {
    logic [VidW-1:0]           src;
    logic [VidW-1:0]           dst;
    logic signed [WeightW-1:0] wgt;
    logic                      last;
  } edge_item_t;

  typedef struct {
    logic                      ev;
    logic [VidW-1:0]           src;
    logic [VidW-1:0]           dst;
    logic signed [WeightW-1:0] wgt;
    logic signed [SumW-1:0]    tot;
    logic                      re;
    logic                      df;
  } tree_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [VidW-1:0] src_vertex_i = '0;
  logic [VidW-1:0] dst_vertex_i = '0;
  logic signed [WeightW-1:0] weight_i = '0;
  logic last_edge_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [VcW-1:0] cfg_wdata_i = '0;
  logic result_valid_o, edge_valid_o, run_end_o, dropped_flag_o;
  logic [VidW-1:0] tree_src_o, tree_dst_o;
  logic signed [WeightW-1:0] tree_weight_o;
  logic signed [SumW-1:0] total_weight_o;

  kruskal_minimum_spanning_tree_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  edge_item_t pending_edges[$];
  tree_res_t  tree_expect[$];
  int errors = 0;
  int gap_left = 0;
  bit calm = 0;
  logic took = 1'b0;

  // graph model state
  logic [VcW-1:0] vcount = 7'd64;
  edge_item_t graph_edges[$];
  bit drop_seen = 0;
  int parent[MaxVertices];
  int rank_of[MaxVertices];

  function automatic int set_root(int v);
    int r, nxt;
    r = v;
    while (parent[r] != r) r = parent[r];
    while (v != r) begin
      nxt = parent[v];
      parent[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  function automatic bit edge_less(edge_item_t a, edge_item_t b);
    if (a.wgt != b.wgt) return a.wgt < b.wgt;
    if (a.src != b.src) return a.src < b.src;
    return a.dst < b.dst;
  endfunction

  task automatic predict_edge(edge_item_t e);
    int lim, ru, rv, taken, j;
    longint t;
    logic signed [SumW-1:0] sum;
    edge_item_t key;
    tree_res_t r;
    lim = (vcount < MaxVertices) ? vcount : MaxVertices;
    if (e.src >= lim || e.dst >= lim || graph_edges.size() >= MaxEdges) drop_seen = 1;
    else graph_edges.push_back(e);
    if (!e.last) return;
    for (int i = 1; i < graph_edges.size(); i++) begin
      key = graph_edges[i];
      j = i;
      while (j > 0 && edge_less(key, graph_edges[j-1])) begin
        graph_edges[j] = graph_edges[j-1];
        j--;
      end
      graph_edges[j] = key;
    end
    for (int i = 0; i < MaxVertices; i++) begin
      parent[i] = i;
      rank_of[i] = 0;
    end
    sum = '0;
    taken = 0;
    foreach (graph_edges[i]) begin
      ru = set_root(graph_edges[i].src);
      rv = set_root(graph_edges[i].dst);
      if (ru == rv || taken >= 63) continue;
      t = longint'(sum) + longint'(graph_edges[i].wgt);
      if (t > 2097151) t = 2097151;
      if (t < -2097152) t = -2097152;
      sum = t[SumW-1:0];
      if (rank_of[ru] > rank_of[rv]) parent[rv] = ru;
      else begin
        parent[ru] = rv;
        if (rank_of[ru] == rank_of[rv] && rank_of[rv] < 7) rank_of[rv]++;
      end
      r = '{1'b1, graph_edges[i].src, graph_edges[i].dst, graph_edges[i].wgt, sum, 1'b0,
            drop_seen};
      tree_expect.push_back(r);
      taken++;
    end
    r = '{1'b0, '0, '0, '0, sum, 1'b1, drop_seen};
    tree_expect.push_back(r);
    graph_edges.delete();
    drop_seen = 0;
  endtask

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // transfer accepted at rising edge
  always @(posedge clk_i) begin
    took <= start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      predict_edge(pending_edges.pop_front());
      gap_left = pick_gap();
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_edges.size() > 0) begin
        src_vertex_i <= pending_edges[0].src;
        dst_vertex_i <= pending_edges[0].dst;
        weight_i <= pending_edges[0].wgt;
        last_edge_i <= pending_edges[0].last;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tree_res_t x;
    if (rst_ni && result_valid_o) begin
      if (tree_expect.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        x = tree_expect.pop_front();
        if (x.ev !== edge_valid_o || x.src !== tree_src_o || x.dst !== tree_dst_o ||
            x.wgt !== tree_weight_o || x.tot !== total_weight_o ||
            x.re !== run_end_o || x.df !== dropped_flag_o) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t: exp ev%0b %0d-%0d w%0d tot%0d end%0b drop%0b",
                     $realtime, x.ev, x.src, x.dst, x.wgt, x.tot, x.re, x.df);
            $display("  got ev%0b %0d-%0d w%0d tot%0d end%0b drop%0b",
                     edge_valid_o, tree_src_o, tree_dst_o, tree_weight_o,
                     total_weight_o, run_end_o, dropped_flag_o);
          end
        end
      end
    end
  end

  task automatic add_edge(int s, int d, int w, bit last);
    edge_item_t e;
    e.src = VidW'(s);
    e.dst = VidW'(d);
    e.wgt = WeightW'(w);
    e.last = last;
    pending_edges.push_back(e);
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || start_i || tree_expect.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_vcount(int v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= VcW'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = VcW'(v);
  endtask

  task automatic random_graph(int n_edges, int hi_id, bit tight_w, int oob_pct);
    int s, d, w;
    for (int i = 0; i < n_edges; i++) begin
      s = $urandom_range(0, hi_id);
      d = ($urandom_range(0, 9) == 0) ? s : $urandom_range(0, hi_id);
      if ($urandom_range(0, 99) < oob_pct) d = $urandom_range(0, 63);
      w = tight_w ? $urandom_range(0, 6) - 3 : $urandom_range(0, 65535) - 32768;
      add_edge(s, d, w, i == n_edges - 1);
    end
  endtask

  initial begin
    int vc, ne;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, self loop, ties, high ids
    add_edge(63, 0, -32768, 0);
    add_edge(0, 63, 32767, 0);
    add_edge(5, 5, -100, 0);
    add_edge(1, 2, 0, 0);
    add_edge(2, 1, 0, 0);
    add_edge(1, 2, 0, 0);
    add_edge(42, 21, -1, 0);
    add_edge(21, 63, 1, 1);
    set_vcount(0);
    add_edge(0, 0, 7, 0);
    add_edge(3, 1, 9, 1);
    set_vcount(1);
    add_edge(0, 0, 5, 0);
    add_edge(0, 1, 5, 1);
    set_vcount(127);
    add_edge(63, 62, 32767, 0);
    add_edge(62, 61, 32767, 1);
    set_vcount(2);
    add_edge(0, 1, -5, 0);
    add_edge(1, 0, -6, 0);
    add_edge(2, 0, 3, 1);
    for (int ph = 0; ph < 30; ph++) begin
      case ($urandom_range(0, 5))
        0: vc = 64;
        1: vc = $urandom_range(65, 127);
        2: vc = $urandom_range(1, 4);
        default: vc = $urandom_range(1, 63);
      endcase
      set_vcount(vc);
      calm = (ph % 7 == 3);
      ne = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      random_graph(ne, (vc > 64 ? 64 : vc) - 1, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) * 10);
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end
endmodule
